[design/wrar_pkg.sv]
package wrar_pkg;

    localparam int WINDOW        = 20;
    localparam int ANGLE_W       = 9;
    localparam int PERIOD_W      = 16;
    localparam int RATE_W        = 15;
    localparam int RATE_SCALE    = 1000;
    localparam int RATE_SCALE_W  = $clog2(RATE_SCALE + 1);
    localparam int WIN_IDX_W     = $clog2(WINDOW);
    localparam int WIN_CNT_W     = $clog2(WINDOW + 1);
    localparam int DIVIDEND_W    = ANGLE_W + RATE_SCALE_W;
    localparam int DIVISOR_W     = $clog2(WINDOW * ((1 << PERIOD_W) - 1) + 1);
    localparam int DIV_CNT_W     = $clog2(DIVIDEND_W + 1);

    localparam logic [RATE_W-1:0]   RATE_MAX    = {RATE_W{1'b1}};
    localparam logic [PERIOD_W-1:0] PERIOD_RST  = PERIOD_W'(1);

    typedef struct packed {
        logic busy;
        logic done;
    } wrar_div_status_t;

endpackage

[design/wrar_ring.sv]
module wrar_ring
    import wrar_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic                 restart,
    input  logic [ANGLE_W-1:0]   angle,
    input  logic [WIN_IDX_W-1:0] rd_idx,
    output logic [ANGLE_W-1:0]   rd_data,
    output logic                 full
);

    logic [ANGLE_W-1:0]   ring_reg [WINDOW];
    logic [WIN_IDX_W-1:0] slot_reg, slot_next, slot_cur;
    logic [WIN_CNT_W-1:0] held_reg, held_next, held_cur;

    always_comb begin
        slot_cur  = restart ? '0 : slot_reg;
        held_cur  = restart ? '0 : held_reg;
        slot_next = (slot_cur == WIN_IDX_W'(WINDOW - 1)) ? '0 : slot_cur + 1'b1;
        held_next = (held_cur < WIN_CNT_W'(WINDOW)) ? held_cur + 1'b1 : held_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            held_reg <= '0;
        end else if (wr_en) begin
            slot_reg <= slot_next;
            held_reg <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_reg[slot_cur] <= angle;
        end
    end

    assign rd_data = ring_reg[rd_idx];
    assign full    = (held_reg == WIN_CNT_W'(WINDOW));

endmodule

[design/wrar_divider.sv]
module wrar_divider
    import wrar_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output wrar_div_status_t      status
);

    logic [DIVIDEND_W-1:0] quot_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    shifted;
    logic                  ge;

    always_comb begin
        shifted = {rem_reg, quot_reg[DIVIDEND_W-1]};
        ge      = (shifted >= {1'b0, divisor});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIVIDEND_W);
                quot_reg <= dividend;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                quot_reg <= {quot_reg[DIVIDEND_W-2:0], ge};
                rem_reg  <= ge ? DIVISOR_W'(shifted - {1'b0, divisor})
                               : shifted[DIVISOR_W-1:0];
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient    = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[design/window_range_angular_rate_unit.sv]
// Channel  Ports                                  Direction  Moves
// input    s_valid s_ready s_angle_deg s_restart  in         one angle sample
// result   m_valid m_ready m_rate_valid            out        one rate result
//          m_rate_deg_per_s
// config   cfg_wr_en cfg_wr_data                   in         sample period, ms
//
// A sample with a partial window goes from ST_CHECK straight to ST_FINISH, with no rate.
// A full window runs ST_CHECK, ST_SCAN, ST_MUL, ST_LAUNCH, ST_DIV and ST_FINISH:
// one ring entry at a time through the shared min/max compare, then one
// quotient bit per cycle in the restoring divider.
// Reset (aresetn, synchronous, low) empties the window and sets the period to 1.
// A result waiting on m_ready does not block the next sample; only the final
// result load waits for the output register to free up.
module window_range_angular_rate_unit
    import wrar_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ANGLE_W-1:0]  s_angle_deg,
    input  logic                s_restart,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_rate_valid,
    output logic [RATE_W-1:0]   m_rate_deg_per_s,
    input  logic                cfg_wr_en,
    input  logic [PERIOD_W-1:0] cfg_wr_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_MUL,
        ST_LAUNCH,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                state_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [WIN_IDX_W-1:0]  idx_reg;
    logic [ANGLE_W-1:0]    lo_reg;
    logic [ANGLE_W-1:0]    hi_reg;
    logic [DIVIDEND_W-1:0] dividend_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic                  res_valid_reg;
    logic [RATE_W-1:0]     res_rate_reg;
    logic                  m_valid_reg;
    logic                  m_rate_valid_reg;
    logic [RATE_W-1:0]     m_rate_reg;

    logic                  accept;
    logic                  ring_full;
    logic [ANGLE_W-1:0]    rd_data;
    logic [DIVIDEND_W-1:0] quotient;
    wrar_div_status_t      div_status;
    logic [PERIOD_W-1:0]   period_eff;
    logic                  out_free;
    logic [RATE_W-1:0]     rate_sat;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign period_eff = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign rate_sat = (quotient > DIVIDEND_W'(RATE_MAX)) ? RATE_MAX : quotient[RATE_W-1:0];

    wrar_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (accept),
        .restart (s_restart),
        .angle   (s_angle_deg),
        .rd_idx  (idx_reg),
        .rd_data (rd_data),
        .full    (ring_full)
    );

    wrar_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_LAUNCH),
        .dividend (dividend_reg),
        .divisor  (divisor_reg),
        .quotient (quotient),
        .status   (div_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RST;
        end else if (cfg_wr_en) begin
            period_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == ST_FINISH) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    idx_reg <= '0;
                    lo_reg  <= {ANGLE_W{1'b1}};
                    hi_reg  <= '0;
                    if (ring_full) begin
                        state_reg <= ST_SCAN;
                    end else begin
                        res_valid_reg <= 1'b0;
                        res_rate_reg  <= '0;
                        state_reg     <= ST_FINISH;
                    end
                end
                ST_SCAN: begin
                    if (rd_data < lo_reg) begin
                        lo_reg <= rd_data;
                    end
                    if (rd_data > hi_reg) begin
                        hi_reg <= rd_data;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == WIN_IDX_W'(WINDOW - 1)) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    dividend_reg <= DIVIDEND_W'(hi_reg - lo_reg) * DIVIDEND_W'(RATE_SCALE);
                    divisor_reg  <= DIVISOR_W'(WINDOW) * DIVISOR_W'(period_eff);
                    state_reg    <= ST_LAUNCH;
                end
                ST_LAUNCH: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_status.done) begin
                        res_valid_reg <= 1'b1;
                        res_rate_reg  <= rate_sat;
                        state_reg     <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_rate_valid_reg <= res_valid_reg;
                        m_rate_reg       <= res_rate_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_rate_valid     = m_rate_valid_reg;
    assign m_rate_deg_per_s = m_rate_reg;

endmodule

[dv/window_range_angular_rate_unit_checker.sv]
`timescale 1ns / 1ps

module window_range_angular_rate_unit_checker
    import wrar_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [ANGLE_W-1:0]  s_angle_deg,
    input  logic                s_restart,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic                m_rate_valid,
    input  logic [RATE_W-1:0]   m_rate_deg_per_s,
    input  logic                cfg_wr_en,
    input  logic [PERIOD_W-1:0] cfg_wr_data,
    output int                  mismatches,
    output int                  rates_pending
);

    typedef struct packed {
        logic              valid;
        logic [RATE_W-1:0] rate;
    } rate_result_t;

    rate_result_t                    expected_rates[$];
    logic [WINDOW-1:0][ANGLE_W-1:0]  angle_ring;
    int                              ring_slot;
    int                              angles_held;
    logic [PERIOD_W-1:0]             period_ms;
    int                              fail_total;

    initial begin
        mismatches    = 0;
        rates_pending = 0;
        fail_total    = 0;
        angle_ring    = '0;
        ring_slot     = 0;
        angles_held   = 0;
        period_ms     = PERIOD_RST;
    end

    function automatic rate_result_t window_rate(input logic [WINDOW-1:0][ANGLE_W-1:0] ring,
                                                 input logic [PERIOD_W-1:0] period);
        rate_result_t res;
        longint       lo;
        longint       hi;
        longint       divisor;
        longint       quotient;
        lo = 1023;
        hi = 0;
        for (int i = 0; i < WINDOW; i++) begin
            if (longint'(ring[i]) < lo) lo = longint'(ring[i]);
            if (longint'(ring[i]) > hi) hi = longint'(ring[i]);
        end
        divisor  = longint'(WINDOW) * ((period == '0) ? 64'd1 : longint'(period));
        quotient = ((hi - lo) * RATE_SCALE) / divisor;
        if (quotient > longint'(RATE_MAX)) quotient = longint'(RATE_MAX);
        res.valid = 1'b1;
        res.rate  = RATE_W'(quotient);
        return res;
    endfunction

    always @(posedge aclk) begin
        rate_result_t exp_res;
        if (!aresetn) begin
            expected_rates.delete();
            angle_ring  = '0;
            ring_slot   = 0;
            angles_held = 0;
            period_ms   = PERIOD_RST;
        end else begin
            if (cfg_wr_en) period_ms = cfg_wr_data;

            if (s_valid && s_ready) begin
                if (s_restart) begin
                    ring_slot   = 0;
                    angles_held = 0;
                end
                angle_ring[ring_slot] = s_angle_deg;
                ring_slot = (ring_slot + 1 >= WINDOW) ? 0 : ring_slot + 1;
                if (angles_held < WINDOW) angles_held++;
                if (angles_held < WINDOW) begin
                    exp_res = '0;
                end else begin
                    exp_res = window_rate(angle_ring, period_ms);
                end
                expected_rates.push_back(exp_res);
            end

            if (m_valid && m_ready) begin
                if (expected_rates.size() == 0) begin
                    $display("%0t: unexpected result rate_valid=%0b rate_deg_per_s=%0d",
                             $time, m_rate_valid, m_rate_deg_per_s);
                    fail_total++;
                end else begin
                    exp_res = expected_rates.pop_front();
                    if (m_rate_valid !== exp_res.valid) begin
                        $display("%0t: rate_valid expected %0b actual %0b",
                                 $time, exp_res.valid, m_rate_valid);
                        fail_total++;
                    end
                    if (m_rate_deg_per_s !== exp_res.rate) begin
                        $display("%0t: rate_deg_per_s expected %0d actual %0d",
                                 $time, exp_res.rate, m_rate_deg_per_s);
                        fail_total++;
                    end
                end
            end
        end
        mismatches    <= fail_total;
        rates_pending <= expected_rates.size();
    end

endmodule

[dv/window_range_angular_rate_unit_test.sv]
`timescale 1ns / 1ps

module window_range_angular_rate_unit_test
    import wrar_pkg::*;
;

    localparam int QUIET_LIMIT = 4000;
    localparam int DIRECTED_N  = 25;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [ANGLE_W-1:0]  s_angle_deg;
    logic                s_restart;
    logic                m_valid;
    logic                m_ready;
    logic                m_rate_valid;
    logic [RATE_W-1:0]   m_rate_deg_per_s;
    logic                cfg_wr_en;
    logic [PERIOD_W-1:0] cfg_wr_data;

    int mismatches;
    int rates_pending;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    int drift_angle;

    logic [ANGLE_W-1:0] directed_angles [DIRECTED_N] = '{
        0, 511, 359, 360, 256, 255, 1, 170, 341, 90,
        180, 270, 45, 135, 225, 315, 10, 20, 30, 40,
        100, 359, 0, 200, 300
    };

    window_range_angular_rate_unit uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_angle_deg      (s_angle_deg),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rate_valid     (m_rate_valid),
        .m_rate_deg_per_s (m_rate_deg_per_s),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data)
    );

    window_range_angular_rate_unit_checker rate_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_angle_deg      (s_angle_deg),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rate_valid     (m_rate_valid),
        .m_rate_deg_per_s (m_rate_deg_per_s),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .mismatches       (mismatches),
        .rates_pending    (rates_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("window_range_angular_rate_unit: mismatch");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic [ANGLE_W-1:0] angle, input logic restart);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_angle_deg <= angle;
        s_restart   <= restart;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (rates_pending != 0);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] period);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= period;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_random(input int count);
        int                 pick;
        logic [ANGLE_W-1:0] angle;
        logic               restart;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                angle = ANGLE_W'($urandom_range(359));
            end else if (pick < 75) begin
                angle = ANGLE_W'($urandom);
            end else begin
                // track a slowly moving angle
                angle = ANGLE_W'((drift_angle + 360 + $urandom_range(20) - 10) % 360);
            end
            drift_angle = int'(angle);
            restart = ($urandom_range(99) < 3);
            send_sample(angle, restart);
            if ($urandom_range(59) == 0) drain_results();
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_angle_deg   = '0;
        s_restart     = 1'b0;
        m_ready       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        send_idle_pct = 18;
        recv_idle_pct = 52;
        quiet_cycles  = 0;
        drift_angle   = 180;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset period, restart on empty and mid stream, out-of-range angles
        for (int i = 0; i < DIRECTED_N; i++) begin
            send_sample(directed_angles[i], (i == 0) || (i == 20));
        end

        drain_results();
        write_period('0);
        run_random(250);

        drain_results();
        send_idle_pct = 52;
        recv_idle_pct = 18;
        write_period({PERIOD_W{1'b1}});
        run_random(250);

        drain_results();
        write_period(PERIOD_W'($urandom_range(100, 1)));
        run_random(250);

        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_period(PERIOD_RST);
        run_random(250);

        drain_results();
        repeat (WINDOW + DIVIDEND_W + 20) @(posedge aclk);

        if (mismatches == 0 && rates_pending == 0) begin
            $display("window_range_angular_rate_unit: match");
        end else begin
            $display("window_range_angular_rate_unit: mismatch");
        end
        $finish;
    end

endmodule
